/* rtl/shpd_pkg.sv */
// ----------------------------------------------------------------------------
// shpd_pkg
// Types and constants shared by the sync header packet deframer.
// ----------------------------------------------------------------------------
package shpd_pkg;

   localparam int MAX_PAYLOAD  = 256;
   localparam int HEADER_BYTES = 8;
   localparam int CHECK_SPAN   = 6;
   localparam int PAY_CNT_W    = $clog2(MAX_PAYLOAD + 1);

   localparam logic [7:0]  SYNC_VALUE_RST   = 8'd170;
   localparam logic [15:0] SYNC_TIMEOUT_RST = 16'd1000;
   localparam logic [15:0] BYTE_TIMEOUT_RST = 16'd100;

   typedef enum logic [1:0] {
      REG_SYNC_VALUE   = 2'd0,
      REG_SYNC_TIMEOUT = 2'd1,
      REG_BYTE_TIMEOUT = 2'd2,
      REG_UNUSED       = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_TIMEOUT   = 2'd1,
      ST_TOO_LONG  = 2'd2,
      ST_BAD_CHECK = 2'd3
   } status_type;

   typedef enum logic {
      KIND_BYTE = 1'b0,
      KIND_TICK = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] rx_byte;
   } req_word_type;

   typedef struct packed {
      logic        payload_valid;
      logic [7:0]  data_byte;
      logic [7:0]  byte_index;
      logic [7:0]  packet_type;
      logic [31:0] packet_offset;
      logic [15:0] packet_length;
      status_type  status;
      logic        last;
   } rsp_word_type;

endpackage

/* rtl/sync_header_packet_deframer.sv */
// ----------------------------------------------------------------------------
// sync_header_packet_deframer
// Hunts for a sync byte, gathers an eight byte header, streams payload bytes
// and closes each packet attempt with a status word.
// ----------------------------------------------------------------------------
// One request word (a received byte or a timeout tick) is taken per clock;
// its result, if any, lands in the single response register the next cycle,
// and a new request is taken while that response waits as long as rsp_ready
// frees the register in the same cycle. The rate is set by the registered
// state update and that one-word response register. Header bytes before the
// last, non-sync bytes while hunting and ticks below the active timeout give
// no response. The CSR port is always ready; index 3 is ignored.
module sync_header_packet_deframer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  shpd_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output shpd_pkg::rsp_word_type rsp_word,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [15:0]           csr_data
);
   import shpd_pkg::*;

   typedef enum logic [1:0] {
      PH_HUNT    = 2'd0,
      PH_HEADER  = 2'd1,
      PH_PAYLOAD = 2'd2
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [2:0]             header_count_ff, header_count_in;
   logic [7:0]             held_type_ff, held_type_in;
   logic [31:0]            held_offset_ff, held_offset_in;
   logic [15:0]            held_length_ff, held_length_in;
   logic [7:0]             expected_check_ff, expected_check_in;
   logic [7:0]             running_xor_ff, running_xor_in;
   logic [PAY_CNT_W-1:0]   payload_count_ff, payload_count_in;
   logic [15:0]            idle_ticks_ff, idle_ticks_in;
   logic [7:0]             sync_value_ff;
   logic [15:0]            sync_timeout_ff, byte_timeout_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_word_type           rsp_word_ff, rsp_word_in;

   logic                   accept;
   logic                   emit;
   rsp_word_type           result;
   logic [15:0]            limit;
   logic [16:0]            ticks_nx;
   logic [PAY_CNT_W-1:0]   count_nx;
   logic [7:0]             xor_nx;
   logic [7:0]             b;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   assign b        = req_word.rx_byte;
   assign limit    = (phase_ff == PH_HUNT) ? sync_timeout_ff : byte_timeout_ff;
   assign ticks_nx = {1'b0, idle_ticks_ff} + 17'd1;
   assign count_nx = payload_count_ff + PAY_CNT_W'(1);
   assign xor_nx   = running_xor_ff ^ b;

   always_comb begin
      phase_in          = phase_ff;
      header_count_in   = header_count_ff;
      held_type_in      = held_type_ff;
      held_offset_in    = held_offset_ff;
      held_length_in    = held_length_ff;
      expected_check_in = expected_check_ff;
      running_xor_in    = running_xor_ff;
      payload_count_in  = payload_count_ff;
      idle_ticks_in     = idle_ticks_ff;
      emit              = 1'b0;
      result            = '0;
      result.packet_type   = held_type_ff;
      result.packet_offset = held_offset_ff;
      result.packet_length = held_length_ff;
      result.status        = ST_OK;
      result.last          = 1'b1;

      if (req_word.kind == KIND_TICK) begin
         if (ticks_nx >= {1'b0, limit}) begin
            emit   = 1'b1;
            result = '0;
            result.status = ST_TIMEOUT;
            result.last   = 1'b1;
            phase_in         = PH_HUNT;
            header_count_in  = '0;
            payload_count_in = '0;
            running_xor_in   = '0;
            idle_ticks_in    = '0;
         end else begin
            idle_ticks_in = ticks_nx[15:0];
         end
      end else begin
         idle_ticks_in = '0;
         case (phase_ff)
            PH_HUNT: begin
               if (b == sync_value_ff) begin
                  phase_in          = PH_HEADER;
                  header_count_in   = '0;
                  running_xor_in    = '0;
                  held_type_in      = '0;
                  held_offset_in    = '0;
                  held_length_in    = '0;
                  expected_check_in = '0;
               end
            end
            PH_HEADER: begin
               header_count_in = header_count_ff + 3'd1;
               if (header_count_ff != 3'(HEADER_BYTES - 1)) begin
                  running_xor_in = xor_nx;
               end
               case (header_count_ff)
                  3'd0: held_type_in = b;
                  3'd1: held_offset_in[7:0]   = b;
                  3'd2: held_offset_in[15:8]  = b;
                  3'd3: held_offset_in[23:16] = b;
                  3'd4: held_offset_in[31:24] = b;
                  3'd5: held_length_in[7:0]   = b;
                  3'd6: held_length_in[15:8]  = b;
                  default: begin
                     expected_check_in = b;
                     if (held_length_ff > 16'(MAX_PAYLOAD)) begin
                        emit          = 1'b1;
                        result.status = ST_TOO_LONG;
                     end else if (held_length_ff == '0) begin
                        emit          = 1'b1;
                        result.status = (running_xor_ff == b) ? ST_OK : ST_BAD_CHECK;
                     end
                     if (emit) begin
                        phase_in        = PH_HUNT;
                        header_count_in = '0;
                        running_xor_in  = '0;
                     end else begin
                        phase_in = PH_PAYLOAD;
                     end
                     payload_count_in = '0;
                  end
               endcase
            end
            PH_PAYLOAD: begin
               emit                 = 1'b1;
               result.payload_valid = 1'b1;
               result.data_byte     = b;
               result.byte_index    = 8'(payload_count_ff);
               running_xor_in       = xor_nx;
               payload_count_in     = count_nx;
               if (17'(count_nx) >= 17'(held_length_ff)) begin
                  result.status    = (xor_nx == expected_check_ff) ? ST_OK : ST_BAD_CHECK;
                  result.last      = 1'b1;
                  phase_in         = PH_HUNT;
                  header_count_in  = '0;
                  payload_count_in = '0;
                  running_xor_in   = '0;
               end else begin
                  result.last = 1'b0;
               end
            end
            default: begin
               phase_in         = PH_HUNT;
               header_count_in  = '0;
               payload_count_in = '0;
               running_xor_in   = '0;
            end
         endcase
      end

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_word_in  = rsp_word_ff;
      if (accept && emit) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_HUNT;
         header_count_ff   <= '0;
         held_type_ff      <= '0;
         held_offset_ff    <= '0;
         held_length_ff    <= '0;
         expected_check_ff <= '0;
         running_xor_ff    <= '0;
         payload_count_ff  <= '0;
         idle_ticks_ff     <= '0;
         sync_value_ff     <= SYNC_VALUE_RST;
         sync_timeout_ff   <= SYNC_TIMEOUT_RST;
         byte_timeout_ff   <= BYTE_TIMEOUT_RST;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff          <= phase_in;
            header_count_ff   <= header_count_in;
            held_type_ff      <= held_type_in;
            held_offset_ff    <= held_offset_in;
            held_length_ff    <= held_length_in;
            expected_check_ff <= expected_check_in;
            running_xor_ff    <= running_xor_in;
            payload_count_ff  <= payload_count_in;
            idle_ticks_ff     <= idle_ticks_in;
         end
         if (csr_valid && csr_ready) begin
            case (reg_index_type'(csr_index))
               REG_SYNC_VALUE:   sync_value_ff   <= csr_data[7:0];
               REG_SYNC_TIMEOUT: sync_timeout_ff <= csr_data;
               REG_BYTE_TIMEOUT: byte_timeout_ff <= csr_data;
               default: ;
            endcase
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_word_ff <= rsp_word_in;
   end

   a_payload_len_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |->
         held_length_ff != '0 && held_length_ff <= 16'(MAX_PAYLOAD))
      else $error("payload phase with out-of-range length");

   a_payload_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> 17'(payload_count_ff) < 17'(held_length_ff))
      else $error("payload count passed header length");

   a_timeout_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_word_ff.status == ST_TIMEOUT |->
         rsp_word_ff.last && !rsp_word_ff.payload_valid &&
         rsp_word_ff.packet_length == '0)
      else $error("timeout word carries data");

   a_mid_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_word_ff.last |->
         rsp_word_ff.payload_valid && rsp_word_ff.status == ST_OK)
      else $error("non-last word is not a clean payload byte");

   a_hunt_clear: assert property (@(posedge clock) disable iff (reset)
      accept && emit && result.last |=>
         phase_ff == PH_HUNT && running_xor_ff == '0 && header_count_ff == '0)
      else $error("packet end did not return to hunt");

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives sync_header_packet_deframer with byte and tick words under random
// valid/ready idling, predicts every response word from its own model of
// the framing state, and compares accepted responses field by field.
// ----------------------------------------------------------------------------
module testbench;
   import shpd_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;

   typedef enum logic [1:0] {
      HUNTING    = 2'd0,
      IN_HEADER  = 2'd1,
      IN_PAYLOAD = 2'd2
   } frame_phase_type;

   class deframe_scoreboard;
      logic [7:0]      sync_value;
      logic [15:0]     sync_to;
      logic [15:0]     byte_to;
      frame_phase_type ph;
      int              header_count;
      logic [7:0]      held_type;
      logic [31:0]     held_offset;
      logic [15:0]     held_length;
      logic [7:0]      expected_check;
      logic [7:0]      running_xor;
      logic [15:0]     payload_count;
      logic [16:0]     idle_ticks;
      rsp_word_type    expected_rsp[$];
      int              mismatches;

      function new();
         sync_value     = SYNC_VALUE_RST;
         sync_to        = SYNC_TIMEOUT_RST;
         byte_to        = BYTE_TIMEOUT_RST;
         held_type      = '0;
         held_offset    = '0;
         held_length    = '0;
         expected_check = '0;
         mismatches     = 0;
         restart_hunt();
      endfunction

      function void restart_hunt();
         ph            = HUNTING;
         header_count  = 0;
         payload_count = '0;
         running_xor   = '0;
         idle_ticks    = '0;
      endfunction

      function int pending();
         return expected_rsp.size();
      endfunction

      function void write_register(logic [1:0] idx, logic [15:0] data);
         case (reg_index_type'(idx))
            REG_SYNC_VALUE:   sync_value = data[7:0];
            REG_SYNC_TIMEOUT: sync_to    = data;
            REG_BYTE_TIMEOUT: byte_to    = data;
            default: ;
         endcase
      endfunction

      function void with_header(ref rsp_word_type r);
         r.packet_type   = held_type;
         r.packet_offset = held_offset;
         r.packet_length = held_length;
      endfunction

      // advance the framing state by one word, queue the response it causes
      function void note_request(req_word_type w);
         rsp_word_type r;
         logic [15:0]  lim;
         logic [7:0]   b;
         logic [15:0]  idx;
         int           n;
         r = '0;
         b = w.rx_byte;
         if (w.kind == KIND_TICK) begin
            lim = (ph == HUNTING) ? sync_to : byte_to;
            idle_ticks = idle_ticks + 17'd1;
            if (idle_ticks >= {1'b0, lim}) begin
               r.status = ST_TIMEOUT;
               r.last   = 1'b1;
               expected_rsp.push_back(r);
               restart_hunt();
            end
            return;
         end
         idle_ticks = '0;
         case (ph)
            HUNTING: begin
               if (b == sync_value) begin
                  ph             = IN_HEADER;
                  header_count   = 0;
                  running_xor    = '0;
                  held_type      = '0;
                  held_offset    = '0;
                  held_length    = '0;
                  expected_check = '0;
               end
            end
            IN_HEADER: begin
               n = header_count;
               if (n == 0) held_type = b;
               else if (n <= 4) held_offset[8*(n-1) +: 8] = b;
               else if (n <= CHECK_SPAN) held_length[8*(n-5) +: 8] = b;
               else expected_check = b;
               if (n <= CHECK_SPAN) running_xor ^= b;
               header_count = n + 1;
               if (header_count == HEADER_BYTES) begin
                  with_header(r);
                  r.last = 1'b1;
                  if (held_length > MAX_PAYLOAD) begin
                     r.status = ST_TOO_LONG;
                     expected_rsp.push_back(r);
                     restart_hunt();
                  end else if (held_length == 0) begin
                     r.status = status_type'((running_xor == expected_check) ?
                                             ST_OK : ST_BAD_CHECK);
                     expected_rsp.push_back(r);
                     restart_hunt();
                  end else begin
                     ph            = IN_PAYLOAD;
                     payload_count = '0;
                  end
               end
            end
            IN_PAYLOAD: begin
               idx           = payload_count;
               running_xor  ^= b;
               payload_count = payload_count + 16'd1;
               with_header(r);
               r.payload_valid = 1'b1;
               r.data_byte     = b;
               r.byte_index    = idx[7:0];
               if (payload_count >= held_length) begin
                  r.status = status_type'((running_xor == expected_check) ?
                                          ST_OK : ST_BAD_CHECK);
                  r.last   = 1'b1;
                  expected_rsp.push_back(r);
                  restart_hunt();
               end else begin
                  r.status = ST_OK;
                  expected_rsp.push_back(r);
               end
            end
            default: restart_hunt();
         endcase
      endfunction

      function string show(rsp_word_type w);
         return $sformatf("pv=%0b data=%02h idx=%0d type=%02h off=%08h len=%0d st=%0d last=%0b",
                          w.payload_valid, w.data_byte, w.byte_index, w.packet_type,
                          w.packet_offset, w.packet_length, w.status, w.last);
      endfunction

      function void check_response(rsp_word_type got);
         rsp_word_type exp_w;
         bit           bad;
         if (expected_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected response %s", $time, show(got));
            return;
         end
         exp_w = expected_rsp.pop_front();
         bad = (got.payload_valid !== exp_w.payload_valid) ||
               (got.data_byte     !== exp_w.data_byte)     ||
               (got.byte_index    !== exp_w.byte_index)    ||
               (got.packet_type   !== exp_w.packet_type)   ||
               (got.packet_offset !== exp_w.packet_offset) ||
               (got.packet_length !== exp_w.packet_length) ||
               (got.status        !== exp_w.status)        ||
               (got.last          !== exp_w.last);
         if (bad) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: mismatch\n  expected %s\n  actual   %s",
                        $time, show(exp_w), show(got));
         end
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_word_type rsp_word;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [1:0]   csr_index = '0;
   logic [15:0]  csr_data = '0;

   deframe_scoreboard sb;
   int          cycle_count = 0;
   int          sent_items = 0;
   bit          gaps_on = 1'b1;
   bit          stall_on = 1'b1;
   logic [7:0]  cur_sync = SYNC_VALUE_RST;
   logic [15:0] cur_sync_to = SYNC_TIMEOUT_RST;
   logic [15:0] cur_byte_to = BYTE_TIMEOUT_RST;

   sync_header_packet_deframer DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_ready <= stall_on ? ($urandom_range(0, 99) >= 23) : 1'b1;
   end

   always @(posedge clock) begin
      if (!reset && sb != null) begin
         if (rsp_valid && rsp_ready) sb.check_response(rsp_word);
         if (req_valid && req_ready) sb.note_request(req_word);
         if (csr_valid && csr_ready) sb.write_register(csr_index, csr_data);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // called and returns at a falling edge
   task automatic push_word(input kind_type k, input logic [7:0] b);
      while (gaps_on && $urandom_range(0, 99) < 23) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= '{kind: k, rx_byte: b};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_items++;
      @(negedge clock);
   endtask

   task automatic push_ticks(input int n);
      repeat (n) push_word(KIND_TICK, 8'($urandom));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic set_config(input logic [7:0] sv, input logic [15:0] st,
                             input logic [15:0] bt);
      csr_write(REG_SYNC_VALUE, {8'($urandom), sv});
      csr_write(REG_SYNC_TIMEOUT, st);
      csr_write(REG_BYTE_TIMEOUT, bt);
      csr_write(REG_UNUSED, 16'($urandom));
      csr_valid   <= 1'b0;
      cur_sync    = sv;
      cur_sync_to = st;
      cur_byte_to = bt;
   endtask

   // abort_at: number of header/payload bytes sent before the line goes quiet
   task automatic send_frame(input logic [7:0] ptype, input logic [31:0] poff,
                             input logic [15:0] plen, input bit bad_check,
                             input int abort_at);
      logic [7:0] hdr [8];
      logic [7:0] body [$];
      logic [7:0] chk;
      int         nbody;
      hdr[0] = ptype;
      hdr[1] = poff[7:0];
      hdr[2] = poff[15:8];
      hdr[3] = poff[23:16];
      hdr[4] = poff[31:24];
      hdr[5] = plen[7:0];
      hdr[6] = plen[15:8];
      chk = '0;
      for (int i = 0; i < 7; i++) chk ^= hdr[i];
      nbody = (plen > MAX_PAYLOAD) ? 0 : int'(plen);
      for (int i = 0; i < nbody; i++) begin
         body.push_back(8'($urandom));
         chk ^= body[i];
      end
      if (bad_check) chk ^= 8'($urandom_range(1, 255));
      hdr[7] = chk;
      push_word(KIND_BYTE, cur_sync);
      for (int i = 0; i < 8 + nbody; i++) begin
         if (i == abort_at) begin
            push_ticks((cur_byte_to > 200) ? 200 : ((cur_byte_to == 0) ? 1 : cur_byte_to));
            return;
         end
         if (cur_byte_to > 1 && $urandom_range(0, 9) == 0)
            push_ticks($urandom_range(1, (cur_byte_to > 5) ? 4 : cur_byte_to - 1));
         push_word(KIND_BYTE, (i < 8) ? hdr[i] : body[i-8]);
      end
   endtask

   task automatic random_frame();
      int         r;
      logic [15:0] len;
      int         abort_at;
      r = $urandom_range(0, 99);
      if (r < 10)      len = 16'd0;
      else if (r < 65) len = 16'($urandom_range(1, 8));
      else if (r < 80) len = 16'($urandom_range(9, 40));
      else if (r < 82) len = 16'd256;
      else if (r < 84) len = 16'd255;
      else if (r < 90) len = 16'd257;
      else             len = 16'($urandom_range(257, 65535));
      abort_at = -1;
      if ($urandom_range(0, 19) == 0)
         abort_at = $urandom_range(0, 7 + ((len > MAX_PAYLOAD) ? 0 : int'(len)));
      send_frame(8'($urandom), 32'($urandom), len, ($urandom_range(0, 4) == 0), abort_at);
   endtask

   task automatic random_phase(input int count);
      int start;
      int r;
      start = sent_items;
      while (sent_items - start < count) begin
         r = $urandom_range(0, 99);
         if (r < 70) begin
            random_frame();
         end else if (r < 80) begin
            repeat ($urandom_range(1, 4))
               push_word(KIND_BYTE, ($urandom_range(0, 7) == 0) ? cur_sync : 8'($urandom));
         end else if (r < 90) begin
            push_ticks($urandom_range(0, 5));
         end else begin
            push_ticks((cur_sync_to > 40) ? 40 : ((cur_sync_to == 0) ? 1 : cur_sync_to));
         end
      end
   endtask

   initial begin
      sb = new();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: stray byte, empty frame, oversize frame, bad checksum
      push_word(KIND_BYTE, 8'h00);
      send_frame(8'hFF, 32'hFFFF_FFFF, 16'd0, 1'b0, -1);
      send_frame(8'h00, 32'h0000_0000, 16'hFFFF, 1'b0, -1);
      send_frame(8'h5A, 32'h1234_5678, 16'd1, 1'b1, -1);
      drain();

      // zero sync timeout, then a frame that stalls mid-payload
      set_config(8'h00, 16'd0, 16'd3);
      push_word(KIND_TICK, 8'hFF);
      send_frame(8'($urandom), 32'($urandom), 16'd4, 1'b0, 10);
      random_phase(220);
      drain();

      set_config(8'hFF, 16'd8, 16'd1);
      send_frame(8'($urandom), 32'($urandom), 16'd256, 1'b0, -1);
      random_phase(220);
      drain();

      set_config(8'($urandom), 16'($urandom_range(1, 40)), 16'($urandom_range(1, 12)));
      random_phase(120);
      drain();
      random_phase(120);
      drain();

      gaps_on  = 1'b0;
      stall_on = 1'b0;
      set_config(8'h55, 16'hFFFF, 16'hFFFF);
      push_ticks(100);
      random_phase(150);
      drain();
      gaps_on  = 1'b1;
      stall_on = 1'b1;

      set_config(8'($urandom), 16'($urandom_range(1, 40)), 16'($urandom_range(1, 12)));
      random_phase(220);
      drain();

      repeat (10) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
